@@ hdl/psx_pkg.sv @@
// Shared widths, constants and types of the principal stress extremes unit.
// Used by every module of the unit; depends on nothing else.
package psx_pkg;

   // Width of each stress component at the input.
   localparam int STRESS_WIDTH = 24;

   // Derived arithmetic widths.
   localparam int SUM_W  = STRESS_WIDTH + 1;     // sxx + syy, signed
   localparam int DIFF_W = STRESS_WIDTH + 1;     // |sxx - syy|, unsigned
   localparam int RAD_W  = 2 * DIFF_W;           // d*d + 4*sxy*sxy
   localparam int ROOT_W = RAD_W / 2;            // one root bit per bit pair
   localparam int REM_W  = ROOT_W + 2;           // partial remainder
   localparam int STEP_W = $clog2(ROOT_W);

   // Output field widths.
   localparam int CMP_W = 26;
   localparam int TEN_W = 25;

   // Signed width that holds (s +/- r) and the output limits without overflow.
   localparam int EXT_W = (STRESS_WIDTH + 4 > CMP_W + 2) ? STRESS_WIDTH + 4 : CMP_W + 2;

   localparam logic signed [EXT_W-1:0] CMP_FLOOR = EXT_W'(-(64'sd1 <<< (CMP_W - 1)));
   localparam logic signed [EXT_W-1:0] TEN_CEIL  = EXT_W'((64'sd1 <<< TEN_W) - 64'sd1);

   // Stream payload widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = ((3 * STRESS_WIDTH + 7) / 8) * 8;
   localparam int RSP_DATA_W = ((2 * CMP_W + 2 * TEN_W + 7) / 8) * 8;

   // Job queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // One prepared element waiting for its square root.
   typedef struct packed {
      logic [RAD_W-1:0]        radicand;
      logic signed [SUM_W-1:0] sum;
      logic                    last;
   } job_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

@@ hdl/psx_front.sv @@
// Front end: accepts stress beats, forms s, |d| and |sxy|, then the radicand.
// Depends on psx_pkg; pushes finished jobs into psx_queue.
module psx_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [psx_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic                              req_tlast,
   input  psx_pkg::queue_status_type         queue_status,
   output logic                              push,
   output psx_pkg::job_type                  push_job
);

   logic signed [psx_pkg::STRESS_WIDTH-1:0] sxx, syy, sxy;
   logic signed [psx_pkg::DIFF_W-1:0]       diff;
   logic        [psx_pkg::DIFF_W-1:0]       adiff;
   logic        [psx_pkg::STRESS_WIDTH-1:0] ashear;
   logic signed [psx_pkg::SUM_W-1:0]        sum;
   logic                                    accept;

   logic                                    st_valid_ff, st_valid_in;
   logic signed [psx_pkg::SUM_W-1:0]        st_sum_ff;
   logic        [psx_pkg::DIFF_W-1:0]       st_adiff_ff;
   logic        [psx_pkg::STRESS_WIDTH-1:0] st_ashear_ff;
   logic                                    st_last_ff;

   logic [psx_pkg::RAD_W-1:0]               diff_sq;
   logic [2*psx_pkg::STRESS_WIDTH-1:0]      shear_sq;

   assign sxx = req_tdata[psx_pkg::STRESS_WIDTH-1:0];
   assign syy = req_tdata[2*psx_pkg::STRESS_WIDTH-1:psx_pkg::STRESS_WIDTH];
   assign sxy = req_tdata[3*psx_pkg::STRESS_WIDTH-1:2*psx_pkg::STRESS_WIDTH];

   assign sum    = psx_pkg::SUM_W'(sxx) + psx_pkg::SUM_W'(syy);
   assign diff   = psx_pkg::DIFF_W'(sxx) - psx_pkg::DIFF_W'(syy);
   assign adiff  = diff[psx_pkg::DIFF_W-1] ? psx_pkg::DIFF_W'(-diff) : psx_pkg::DIFF_W'(diff);
   assign ashear = sxy[psx_pkg::STRESS_WIDTH-1] ?
                   psx_pkg::STRESS_WIDTH'(-sxy) : psx_pkg::STRESS_WIDTH'(sxy);

   // The staging register frees up as soon as its job moves into the queue.
   assign push       = st_valid_ff && !queue_status.full;
   assign req_tready = !st_valid_ff || !queue_status.full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      st_valid_in = st_valid_ff;
      if (accept) begin
         st_valid_in = 1'b1;
      end else if (push) begin
         st_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_valid_ff <= 1'b0;
      end else begin
         st_valid_ff <= st_valid_in;
      end
      if (accept) begin
         st_sum_ff    <= sum;
         st_adiff_ff  <= adiff;
         st_ashear_ff <= ashear;
         st_last_ff   <= req_tlast;
      end
   end

   // Both squares are at most 2^(2W), so their sum fits the radicand width.
   assign diff_sq  = st_adiff_ff * st_adiff_ff;
   assign shear_sq = st_ashear_ff * st_ashear_ff;

   assign push_job.radicand = diff_sq + {shear_sq, 2'b00};
   assign push_job.sum      = st_sum_ff;
   assign push_job.last     = st_last_ff;

endmodule

@@ hdl/psx_queue.sv @@
// Short job queue that decouples the front end from the root sequencer.
// Depends on psx_pkg for the job type and depth.
module psx_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  psx_pkg::job_type          push_job,
   input  logic                      pop,
   output psx_pkg::job_type          head_job,
   output psx_pkg::queue_status_type queue_status
);

   psx_pkg::job_type            mem_ff [psx_pkg::QUEUE_DEPTH];
   logic [psx_pkg::QPTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [psx_pkg::QPTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [psx_pkg::QCNT_W-1:0]  count_ff, count_in;

   function automatic logic [psx_pkg::QPTR_W-1:0] next_ptr(
      input logic [psx_pkg::QPTR_W-1:0] ptr
   );
      logic [psx_pkg::QPTR_W-1:0] result;
      if (ptr == psx_pkg::QPTR_W'(psx_pkg::QUEUE_DEPTH - 1)) begin
         result = '0;
      end else begin
         result = ptr + 1'b1;
      end
      return result;
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job           = mem_ff[rd_ptr_ff];
   assign queue_status.full  = (count_ff == psx_pkg::QCNT_W'(psx_pkg::QUEUE_DEPTH));
   assign queue_status.empty = (count_ff == '0);

   no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      !(push && count_ff == psx_pkg::QCNT_W'(psx_pkg::QUEUE_DEPTH)))
      else $error("queue written while full");

   no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      !(pop && count_ff == '0))
      else $error("queue read while empty");

   count_tracks_push: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == psx_pkg::QCNT_W'($past(count_ff) + 1'b1))
      else $error("queue count did not follow a push");

endmodule

@@ hdl/psx_back.sv @@
// Back end: bit-pair restoring square root, principal stress clamp and the
// running set extremes, ending in the result register. Depends on psx_pkg.
module psx_back (
   input  logic                           clock,
   input  logic                           reset,
   input  psx_pkg::queue_status_type      queue_status,
   input  psx_pkg::job_type               head_job,
   output logic                           pop,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [psx_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROOT,
      ST_CLAMP,
      ST_EMIT
   } state_type;

   state_type                         state_ff, state_in;
   logic [psx_pkg::STEP_W-1:0]        step_ff, step_in;
   logic [psx_pkg::RAD_W-1:0]         rad_ff, rad_in;
   logic [psx_pkg::REM_W-1:0]         rem_ff, rem_in;
   logic [psx_pkg::ROOT_W-1:0]        root_ff, root_in;
   logic signed [psx_pkg::SUM_W-1:0]  sum_ff, sum_in;
   logic                              last_ff, last_in;
   logic signed [psx_pkg::CMP_W-1:0]  lmin_ff, lmin_in;
   logic [psx_pkg::TEN_W-1:0]         lmax_ff, lmax_in;
   logic signed [psx_pkg::CMP_W-1:0]  run_min_ff, run_min_in;
   logic [psx_pkg::TEN_W-1:0]         run_max_ff, run_max_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [psx_pkg::CMP_W-1:0]  rsp_cmp_ff, rsp_cmp_in;
   logic [psx_pkg::TEN_W-1:0]         rsp_ten_ff, rsp_ten_in;
   logic signed [psx_pkg::CMP_W-1:0]  rsp_smin_ff, rsp_smin_in;
   logic [psx_pkg::TEN_W-1:0]         rsp_smax_ff, rsp_smax_in;
   logic                              rsp_last_ff, rsp_last_in;

   logic [psx_pkg::REM_W-1:0]         rem_shift, trial;
   logic                              take;
   logic signed [psx_pkg::EXT_W-1:0]  s_ext, r_ext, lo_half, hi_half, lo_clamp, hi_clamp;
   logic signed [psx_pkg::CMP_W-1:0]  new_min;
   logic [psx_pkg::TEN_W-1:0]         new_max;
   logic                              emit_load;

   // One restoring step: bring down the next bit pair and try 4*root + 1.
   assign rem_shift = {rem_ff[psx_pkg::REM_W-3:0], rad_ff[psx_pkg::RAD_W-1 -: 2]};
   assign trial     = {root_ff, 2'b01};
   assign take      = (rem_shift >= trial);

   // Principal values with an arithmetic halving, then sign clamp and range limit.
   assign s_ext    = psx_pkg::EXT_W'(sum_ff);
   assign r_ext    = $signed(psx_pkg::EXT_W'(root_ff));
   assign lo_half  = (s_ext - r_ext) >>> 1;
   assign hi_half  = (s_ext + r_ext) >>> 1;

   always_comb begin
      lo_clamp = (lo_half > 0) ? '0 : lo_half;
      if (lo_clamp < psx_pkg::CMP_FLOOR) begin
         lo_clamp = psx_pkg::CMP_FLOOR;
      end
      hi_clamp = (hi_half < 0) ? '0 : hi_half;
      if (hi_clamp > psx_pkg::TEN_CEIL) begin
         hi_clamp = psx_pkg::TEN_CEIL;
      end
   end

   assign new_min   = (lmin_ff < run_min_ff) ? lmin_ff : run_min_ff;
   assign new_max   = (lmax_ff > run_max_ff) ? lmax_ff : run_max_ff;
   assign emit_load = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_tready);
   assign pop       = (state_ff == ST_IDLE) && !queue_status.empty;

   always_comb begin
      state_in     = state_ff;
      step_in      = step_ff;
      rad_in       = rad_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      sum_in       = sum_ff;
      last_in      = last_ff;
      lmin_in      = lmin_ff;
      lmax_in      = lmax_ff;
      run_min_in   = run_min_ff;
      run_max_in   = run_max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_cmp_in   = rsp_cmp_ff;
      rsp_ten_in   = rsp_ten_ff;
      rsp_smin_in  = rsp_smin_ff;
      rsp_smax_in  = rsp_smax_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         ST_IDLE: begin
            if (pop) begin
               rad_in   = head_job.radicand;
               sum_in   = head_job.sum;
               last_in  = head_job.last;
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = ST_ROOT;
            end
         end
         ST_ROOT: begin
            rad_in  = {rad_ff[psx_pkg::RAD_W-3:0], 2'b00};
            rem_in  = take ? rem_shift - trial : rem_shift;
            root_in = {root_ff[psx_pkg::ROOT_W-2:0], take};
            step_in = step_ff + 1'b1;
            if (step_ff == psx_pkg::STEP_W'(psx_pkg::ROOT_W - 1)) begin
               state_in = ST_CLAMP;
            end
         end
         ST_CLAMP: begin
            lmin_in  = psx_pkg::CMP_W'(lo_clamp);
            lmax_in  = psx_pkg::TEN_W'(hi_clamp);
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_load) begin
               rsp_valid_in = 1'b1;
               rsp_cmp_in   = lmin_ff;
               rsp_ten_in   = lmax_ff;
               rsp_smin_in  = new_min;
               rsp_smax_in  = new_max;
               rsp_last_in  = last_ff;
               run_min_in   = last_ff ? '0 : new_min;
               run_max_in   = last_ff ? '0 : new_max;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         run_min_ff   <= '0;
         run_max_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         run_min_ff   <= run_min_in;
         run_max_ff   <= run_max_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      step_ff     <= step_in;
      rad_ff      <= rad_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      sum_ff      <= sum_in;
      last_ff     <= last_in;
      lmin_ff     <= lmin_in;
      lmax_ff     <= lmax_in;
      rsp_cmp_ff  <= rsp_cmp_in;
      rsp_ten_ff  <= rsp_ten_in;
      rsp_smin_ff <= rsp_smin_in;
      rsp_smax_ff <= rsp_smax_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tdata  = psx_pkg::RSP_DATA_W'({rsp_smax_ff, rsp_smin_ff, rsp_ten_ff, rsp_cmp_ff});

   extremes_bound_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_smin_ff <= rsp_cmp_ff) && (rsp_smax_ff >= rsp_ten_ff))
      else $error("set extremes do not bound the current result");

   extremes_clear_after_last: assert property (@(posedge clock) disable iff (reset)
      (emit_load && last_ff) |=> (run_min_ff == '0) && (run_max_ff == '0))
      else $error("running extremes not cleared after the last element");

   clamp_follows_full_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLAMP) |->
         ($past(state_ff) == ST_ROOT) &&
         ($past(step_ff) == psx_pkg::STEP_W'(psx_pkg::ROOT_W - 1)))
      else $error("clamp entered before the root finished");

endmodule

@@ hdl/principal_stress_extremes_unit.sv @@
// An accepted req beat passes the front staging register, the queue, the root, clamp and
// emit states of the back end and the result register. The back end takes one job at a time
// (idle/pop, 25 bit-pair root steps, clamp, emit) and waits in emit while its result register is full.
// The front stage and the two-entry queue take up to three more beats while the root runs.
// Reset (synchronous, active high) empties the queue, idles the sequencer, drops
// rsp_tvalid and sets the running set extremes to zero; no clearing pass is needed.
module principal_stress_extremes_unit (
   input  logic                           clock,
   input  logic                           reset,
   // Element stress input.
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // tdata, lowest bit up: stress_xx[23:0], stress_yy[47:24], stress_xy[71:48]
   input  logic [psx_pkg::REQ_DATA_W-1:0] req_tdata,
   // tlast: last_in_set
   input  logic                           req_tlast,
   // Principal stress result.
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata, lowest bit up: compressive[25:0], tensile[50:26], set_min[76:51],
   // set_max[101:77], two zero pad bits
   output logic [psx_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tlast: set_done
   output logic                           rsp_tlast
);

   // Jobs flow front -> queue -> back; the queue status lets each side stall alone.
   psx_pkg::queue_status_type queue_status;
   psx_pkg::job_type          push_job;
   psx_pkg::job_type          head_job;
   logic                      push;
   logic                      pop;

   // The front end squares |sxx - syy| and |sxy| and forms the radicand
   // d*d + 4*sxy*sxy together with s = sxx + syy.
   psx_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .queue_status (queue_status),
      .push         (push),
      .push_job     (push_job)
   );

   psx_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_job     (push_job),
      .pop          (pop),
      .head_job     (head_job),
      .queue_status (queue_status)
   );

   // The back end takes one job at a time: the integer root r, then
   // (s - r) >>> 1 and (s + r) >>> 1 with their clamps, then the set extremes.
   // Its result register holds a finished beat while the front keeps accepting.
   psx_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .head_job     (head_job),
      .pop          (pop),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast)
   );

endmodule

@@ tb/psx_result_checker.sv @@
// Checker for the principal stress extremes unit: predicts every result beat and compares it.
// Depends on psx_pkg for the stream widths and the output field widths.
module psx_result_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   // tdata, lowest bit up: stress_xx, stress_yy, stress_xy
   input  logic [psx_pkg::REQ_DATA_W-1:0] req_tdata,
   // tlast: last_in_set
   input  logic                           req_tlast,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // tdata, lowest bit up: compressive, tensile, set_min, set_max, zero pad
   input  logic [psx_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // tlast: set_done
   input  logic                           rsp_tlast,
   output int                             mismatch_count,
   output int                             outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TEN_LO = psx_pkg::CMP_W;
   localparam int MIN_LO = psx_pkg::CMP_W + psx_pkg::TEN_W;
   localparam int MAX_LO = 2 * psx_pkg::CMP_W + psx_pkg::TEN_W;
   localparam longint CMP_LIMIT = -(longint'(1) <<< (psx_pkg::CMP_W - 1));
   localparam longint TEN_LIMIT = (longint'(1) <<< psx_pkg::TEN_W) - 1;

   typedef logic signed [psx_pkg::STRESS_WIDTH-1:0] stress_type;

   typedef struct {
      logic signed [psx_pkg::CMP_W-1:0] compressive;
      logic [psx_pkg::TEN_W-1:0]        tensile;
      logic signed [psx_pkg::CMP_W-1:0] set_min;
      logic [psx_pkg::TEN_W-1:0]        set_max;
      logic                             set_done;
   } principal_beat_type;

   principal_beat_type predicted_stresses[$];
   longint             set_low;
   longint             set_high;

   task automatic report_mismatch(string field, longint got, longint want);
      $display("[%0t] %s: got %0d, expected %0d", $time, field, got, want);
      mismatch_count++;
   endtask

   // Restoring root, one bit pair per step.
   function automatic longint unsigned floor_root(longint unsigned radicand);
      longint unsigned rem;
      longint unsigned root;
      longint unsigned trial;
      rem  = 0;
      root = 0;
      for (int p = 31; p >= 0; p--) begin
         rem   = (rem << 2) | ((radicand >> (2 * p)) & 64'd3);
         trial = (root << 2) | 64'd1;
         if (rem >= trial) begin
            rem  = rem - trial;
            root = (root << 1) | 64'd1;
         end else begin
            root = root << 1;
         end
      end
      return root;
   endfunction

   // Clamped principal stresses of one element; the set fields are filled in by the caller.
   function automatic principal_beat_type principal_pair(stress_type xx, stress_type yy,
                                                         stress_type xy);
      principal_beat_type result;
      longint             sum;
      longint             diff;
      longint             shear;
      longint             radius;
      longint             low;
      longint             high;
      sum    = longint'(xx) + longint'(yy);
      diff   = longint'(xx) - longint'(yy);
      shear  = longint'(xy);
      if (diff < 0) diff = -diff;
      if (shear < 0) shear = -shear;
      radius = longint'(floor_root(longint'(diff * diff + 4 * shear * shear)));
      // The shifts are arithmetic, so odd values round toward minus infinity.
      low  = (sum - radius) >>> 1;
      high = (sum + radius) >>> 1;
      if (low > 0) low = 0;
      if (high < 0) high = 0;
      if (low < CMP_LIMIT) low = CMP_LIMIT;
      if (high > TEN_LIMIT) high = TEN_LIMIT;
      result.compressive = psx_pkg::CMP_W'(low);
      result.tensile     = psx_pkg::TEN_W'(high);
      result.set_min     = '0;
      result.set_max     = '0;
      result.set_done    = 1'b0;
      return result;
   endfunction

   always @(posedge clock) begin : track
      principal_beat_type seen;
      principal_beat_type want;
      if (reset) begin
         predicted_stresses.delete();
         set_low        = 0;
         set_high       = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            seen.compressive = rsp_tdata[TEN_LO-1:0];
            seen.tensile     = rsp_tdata[MIN_LO-1:TEN_LO];
            seen.set_min     = rsp_tdata[MAX_LO-1:MIN_LO];
            seen.set_max     = rsp_tdata[MAX_LO+psx_pkg::TEN_W-1:MAX_LO];
            seen.set_done    = rsp_tlast;
            if (predicted_stresses.size() == 0) begin
               report_mismatch("result beat with none expected", 1, 0);
            end else begin
               want = predicted_stresses.pop_front();
               if (seen.compressive !== want.compressive)
                  report_mismatch("compressive", seen.compressive, want.compressive);
               if (seen.tensile !== want.tensile)
                  report_mismatch("tensile", seen.tensile, want.tensile);
               if (seen.set_min !== want.set_min)
                  report_mismatch("set_min", seen.set_min, want.set_min);
               if (seen.set_max !== want.set_max)
                  report_mismatch("set_max", seen.set_max, want.set_max);
               if (seen.set_done !== want.set_done)
                  report_mismatch("set_done", seen.set_done, want.set_done);
            end
         end
         if (req_tvalid && req_tready) begin
            want = principal_pair(
               req_tdata[psx_pkg::STRESS_WIDTH-1:0],
               req_tdata[2*psx_pkg::STRESS_WIDTH-1:psx_pkg::STRESS_WIDTH],
               req_tdata[3*psx_pkg::STRESS_WIDTH-1:2*psx_pkg::STRESS_WIDTH]);
            if (longint'(want.compressive) < set_low) set_low = want.compressive;
            if (longint'(want.tensile) > set_high) set_high = want.tensile;
            want.set_min  = psx_pkg::CMP_W'(set_low);
            want.set_max  = psx_pkg::TEN_W'(set_high);
            want.set_done = req_tlast;
            predicted_stresses.insert(predicted_stresses.size(), want);
            if (req_tlast) begin
               set_low  = 0;
               set_high = 0;
            end
         end
      end
      outstanding = predicted_stresses.size();
   end

endmodule

@@ tb/tb.sv @@
// Top of the principal stress extremes testbench: clock, reset, stimulus and verdict.
// Depends on psx_pkg, the unit under test and psx_result_checker.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Cycles in a row with no beat on either channel before the run is declared hung.
   // The slowest correct gap is the long receiver hold-off.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int LONG_HOLD      = 400;
   localparam int RANDOM_CHUNK   = 350;

   typedef logic signed [psx_pkg::STRESS_WIDTH-1:0] stress_type;

   localparam stress_type STRESS_MAX = {1'b0, {(psx_pkg::STRESS_WIDTH-1){1'b1}}};
   localparam stress_type STRESS_MIN = {1'b1, {(psx_pkg::STRESS_WIDTH-1){1'b0}}};

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           req_tvalid;
   logic                           req_tready;
   logic [psx_pkg::REQ_DATA_W-1:0] req_tdata;
   logic                           req_tlast;
   logic                           rsp_tvalid;
   logic                           rsp_tready;
   logic [psx_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic                           rsp_tlast;
   int                             mismatch_count;
   int                             outstanding;

   // Idling knobs shared by the stimulus and the receiver. A zero maximum means that
   // side never idles; the long hold is picked up by the receiver before its next beat.
   int req_idle_max;
   int rsp_idle_max;
   int rsp_long_hold;
   int set_left;

   principal_stress_extremes_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   psx_result_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tlast      (rsp_tlast),
      .mismatch_count (mismatch_count),
      .outstanding    (outstanding)
   );

   // 8 ns period.
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Every input is known from time zero; reset is held high from the start and then released
   // on a falling edge, like every other input change.
   initial begin
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      req_idle_max  = 16;
      rsp_idle_max  = 16;
      rsp_long_hold = 0;
      set_left      = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   // Receiver. For each beat it draws a hold-off, keeps tready low that many cycles and
   // then waits with tready high for the handshake. A requested long hold replaces the
   // draw once, so that the unit fills up behind it.
   initial begin : receiver
      int hold;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (rsp_long_hold > 0) begin
            hold          = rsp_long_hold;
            rsp_long_hold = 0;
         end else begin
            hold = $urandom_range(0, rsp_idle_max);
         end
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   // Sends one element. The gap is drawn per beat; with no gap tvalid stays high from the
   // previous beat and only the payload changes on this falling edge.
   task automatic send_element(stress_type xx, stress_type yy, stress_type xy, logic last);
      int gap;
      gap = $urandom_range(0, req_idle_max);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {xy, yy, xx};
      req_tlast  <= last;
      do @(posedge clock); while (!(req_tvalid && req_tready));
      @(negedge clock);
   endtask

   // Holds the sender back until the checker has seen every predicted beat.
   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   // One stress component. Full-range values cover every bit, small values hit the
   // rounding of odd sums, and the extremes stress the widest radicand.
   function automatic stress_type draw_stress(int kind);
      stress_type value;
      case (kind)
         0: begin
            value = stress_type'($urandom);
         end
         1: begin
            value = stress_type'($urandom_range(0, 200) - 100);
         end
         default: begin
            case ($urandom_range(0, 4))
               0: value = STRESS_MAX;
               1: value = STRESS_MIN;
               2: value = '0;
               3: value = '1;
               default: value = stress_type'(1);
            endcase
         end
      endcase
      return value;
   endfunction

   // Random elements grouped into sets of one to a dozen, the last one marked.
   task automatic send_random_elements(int count);
      stress_type xx;
      stress_type yy;
      stress_type xy;
      int         kind;
      repeat (count) begin
         if (set_left == 0) set_left = ($urandom_range(0, 3) == 0) ? 1 : $urandom_range(2, 12);
         kind = $urandom_range(0, 9);
         if (kind < 5) begin
            xx = draw_stress(0);
            yy = draw_stress(0);
            xy = draw_stress(0);
         end else if (kind < 7) begin
            xx = draw_stress(1);
            yy = draw_stress(1);
            xy = draw_stress(1);
         end else if (kind < 9) begin
            xx = draw_stress($urandom_range(0, 2));
            yy = draw_stress($urandom_range(0, 2));
            xy = draw_stress($urandom_range(0, 2));
         end else begin
            // Nearly equal normal stresses: the root is then set almost only by the shear.
            xx = draw_stress(0);
            yy = xx + draw_stress(1);
            xy = draw_stress($urandom_range(0, 1));
         end
         send_element(xx, yy, xy, set_left == 1);
         set_left--;
      end
   endtask

   // Stimulus and verdict.
   initial begin : stimulus
      @(negedge clock);
      while (reset) @(negedge clock);

      // Directed elements. All zero, then one-sided states where one of the clamps
      // holds a value at zero, then the extremes of each field.
      send_element('0, '0, '0, 1'b1);
      send_element(stress_type'(1000), stress_type'(1000), '0, 1'b0);
      send_element(stress_type'(-1000), stress_type'(-1000), '0, 1'b0);
      send_element(STRESS_MAX, STRESS_MAX, STRESS_MAX, 1'b0);
      send_element(STRESS_MIN, STRESS_MIN, STRESS_MIN, 1'b1);
      send_element(STRESS_MAX, STRESS_MIN, '0, 1'b0);
      send_element(STRESS_MIN, STRESS_MAX, '0, 1'b0);
      // The widest radicand: largest difference with the most negative shear.
      send_element(STRESS_MAX, STRESS_MIN, STRESS_MIN, 1'b0);
      send_element(STRESS_MIN, STRESS_MAX, STRESS_MAX, 1'b1);
      send_element('0, '0, STRESS_MAX, 1'b0);
      send_element('0, '0, STRESS_MIN, 1'b1);
      // Small negative elements, the first two with odd sums.
      send_element(stress_type'(-1), '0, '0, 1'b0);
      send_element('0, stress_type'(-3), '0, 1'b0);
      send_element(stress_type'(-1), stress_type'(-1), stress_type'(1), 1'b1);
      // A perfect square radicand, then two radicands that are not squares.
      send_element(stress_type'(3), '0, stress_type'(2), 1'b0);
      send_element(stress_type'(2), '0, stress_type'(-2), 1'b0);
      send_element(stress_type'(1), '0, stress_type'(1), 1'b1);
      // A set whose extremes grow, then one that must start again from zero.
      send_element(stress_type'(5000), stress_type'(-5000), stress_type'(100), 1'b0);
      send_element(stress_type'(-20000), stress_type'(30000), stress_type'(-7), 1'b0);
      send_element(stress_type'(10), stress_type'(10), '0, 1'b1);
      send_element(stress_type'(7), stress_type'(-3), stress_type'(2), 1'b1);
      drain_results();

      // Both sides idle at random.
      send_random_elements(RANDOM_CHUNK);
      drain_results();

      // No idling on either side.
      req_idle_max = 0;
      rsp_idle_max = 0;
      send_random_elements(RANDOM_CHUNK);

      // Back pressure: the receiver holds off while the sender keeps offering beats, so
      // the queue inside the unit fills and req_tready drops.
      rsp_long_hold = LONG_HOLD;
      send_random_elements(24);
      drain_results();

      // Fast sender against a slow receiver.
      rsp_idle_max = 16;
      send_random_elements(RANDOM_CHUNK);
      drain_results();

      // Slow sender against a fast receiver.
      req_idle_max = 16;
      rsp_idle_max = 0;
      send_random_elements(RANDOM_CHUNK);

      drain_results();
      repeat (60) @(posedge clock);
      if (mismatch_count == 0 && outstanding == 0) begin
         $display("principal_stress_extremes_unit: match");
      end else begin
         $display("principal_stress_extremes_unit: mismatch");
      end
      $finish;
   end

   // Watchdog: any beat on either channel restarts the count.
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("principal_stress_extremes_unit: mismatch");
      $finish;
   end

endmodule

@@ filelist.f @@
hdl/psx_pkg.sv
hdl/psx_front.sv
hdl/psx_queue.sv
hdl/psx_back.sv
hdl/principal_stress_extremes_unit.sv
tb/psx_result_checker.sv
tb/tb.sv
